[hdl/ipu_pkg.sv]
`default_nettype none

package ipu_pkg;

	// Commands from the controller to the datapath, at most a few per cycle.
	typedef struct packed {
		logic load;      // capture the operands of an accepted item
		logic init;      // set up the loop and the result of the special cases
		logic mul_start; // register the partial products of one multiplication
		logic mul_end;   // sum the partial products into the selected register
		logic sel_sq;    // 1: square the square register, 0: multiply into the accumulator
		logic shift;     // drop the lowest exponent bit
		logic take_acc;  // the accumulator becomes the result
		logic out_load;  // move the result into the output register
	} ipu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic special; // the result needs no multiplication
		logic u_lsb;   // lowest remaining exponent bit
		logic u_last;  // no exponent bits remain above the lowest one
	} ipu_status_t;

endpackage

`default_nettype wire

[hdl/ipu_in_if.sv]
`default_nettype none

interface ipu_in_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] base;
	logic signed [63:0] exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);
endinterface

`default_nettype wire

[hdl/ipu_out_if.sv]
`default_nettype none

interface ipu_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] power;
	logic               zero_to_negative;

	modport source (output valid, output power, output zero_to_negative, input ready);
	modport sink (input valid, input power, input zero_to_negative, output ready);
endinterface

`default_nettype wire

[hdl/ipu_mul.sv]
`default_nettype none

// Low half of a product, built from three half-width multiplications.
// The partial products are registered on start; the product is valid the next cycle.
module ipu_mul #(
	parameter int WIDTH = 64
) (
	input  wire logic             clk,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output logic      [WIDTH-1:0] product
);

	localparam int HALF = (WIDTH + 1) / 2;
	localparam int FULL = 2 * HALF;

	logic [FULL-1:0] a_ext;
	logic [FULL-1:0] b_ext;
	logic [HALF-1:0] a_lo, a_hi, b_lo, b_hi;
	logic [FULL-1:0] ll;
	logic [HALF-1:0] lh, hl;
	logic [FULL-1:0] ll_s1;
	logic [HALF-1:0] lh_s1, hl_s1;
	logic [FULL-1:0] sum;

	// Split the operands into halves.
	always_comb begin
		a_ext = FULL'(a);
		b_ext = FULL'(b);
		a_lo  = a_ext[HALF-1:0];
		a_hi  = a_ext[FULL-1:HALF];
		b_lo  = b_ext[HALF-1:0];
		b_hi  = b_ext[FULL-1:HALF];
	end

	// The cross products only matter in their low halves.
	always_comb begin
		ll = FULL'(a_lo) * FULL'(b_lo);
		lh = a_lo * b_hi;
		hl = a_hi * b_lo;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ll_s1 <= ll;
			lh_s1 <= lh;
			hl_s1 <= hl;
		end
	end

	// Combine the partial products, wrapping at the full width.
	always_comb begin
		sum     = ll_s1 + {HALF'(lh_s1 + hl_s1), {HALF{1'b0}}};
		product = sum[WIDTH-1:0];
	end

endmodule

`default_nettype wire

[hdl/ipu_dpath.sv]
`default_nettype none

// Operand, accumulator, square and result registers around a shared multiplier.
module ipu_dpath #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic               clk,
	input  wire ipu_pkg::ipu_cmd_t  cmd,
	output ipu_pkg::ipu_status_t    status,
	input  wire logic signed [63:0] base,
	input  wire logic signed [63:0] exponent,
	output logic signed [63:0]      power,
	output logic                    zero_to_negative
);

	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] n_q;
	logic [DATA_WIDTH-1:0] u_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] sq_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  flag_q;
	logic [DATA_WIDTH-1:0] power_q;
	logic                  z2n_q;

	logic [DATA_WIDTH-1:0] mul_a;
	logic [DATA_WIDTH-1:0] product;
	logic                  n_zero, x_one, x_zero, x_mone, n_neg;
	logic [DATA_WIDTH-1:0] spec_res;
	logic                  spec_flag;

	// Classify the operands.
	always_comb begin
		n_zero = (n_q == '0);
		x_one  = (x_q == DATA_WIDTH'(1));
		x_zero = (x_q == '0);
		x_mone = &x_q;
		n_neg  = n_q[DATA_WIDTH-1];
	end

	// Result of the cases that need no multiplication.
	always_comb begin
		spec_res  = '0;
		spec_flag = 1'b0;
		priority if (n_zero || x_one) begin
			spec_res = DATA_WIDTH'(1);
		end else if (n_neg && x_zero) begin
			spec_flag = 1'b1;
		end else if (n_neg && x_mone) begin
			spec_res = n_q[0] ? '1 : DATA_WIDTH'(1);
		end else begin
			spec_res = '0;
		end
	end

	always_comb begin
		status.special = n_zero || x_one || n_neg;
		status.u_lsb   = u_q[0];
		status.u_last  = ((u_q >> 1) == '0);
	end

	// The multiplier takes the accumulator or the square times the square.
	assign mul_a = cmd.sel_sq ? sq_q : acc_q;

	ipu_mul #(
		.WIDTH (DATA_WIDTH)
	) u_mul (
		.clk     (clk),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (sq_q),
		.product (product)
	);

	// Operand capture and loop registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= base[DATA_WIDTH-1:0];
			n_q <= exponent[DATA_WIDTH-1:0];
		end
		if (cmd.init) begin
			acc_q  <= DATA_WIDTH'(1);
			sq_q   <= x_q;
			u_q    <= n_q;
			res_q  <= spec_res;
			flag_q <= spec_flag;
		end
		if (cmd.mul_end && !cmd.sel_sq) begin
			acc_q <= product;
		end
		if (cmd.mul_end && cmd.sel_sq) begin
			sq_q <= product;
		end
		if (cmd.shift) begin
			u_q <= u_q >> 1;
		end
		if (cmd.take_acc) begin
			res_q <= acc_q;
		end
	end

	// Output register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			power_q <= res_q;
			z2n_q   <= flag_q;
		end
	end

	// Sign-extend the result to the field width.
	assign power            = 64'($signed(power_q));
	assign zero_to_negative = z2n_q;

endmodule

`default_nettype wire

[hdl/ipu_ctrl.sv]
`default_nettype none

// Sequencer for square-and-multiply, plus the output valid flag.
module ipu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire ipu_pkg::ipu_status_t status,
	output ipu_pkg::ipu_cmd_t         cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_STEP  = 4'd2;
	localparam logic [3:0] ST_MA1   = 4'd3;
	localparam logic [3:0] ST_MA2   = 4'd4;
	localparam logic [3:0] ST_NEXT  = 4'd5;
	localparam logic [3:0] ST_MS1   = 4'd6;
	localparam logic [3:0] ST_MS2   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.init = 1'b1;
				state_d  = status.special ? ST_FIN : ST_STEP;
			end
			ST_STEP: begin
				state_d = status.u_lsb ? ST_MA1 : ST_NEXT;
			end
			ST_MA1: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MA2;
			end
			ST_MA2: begin
				cmd.mul_end = 1'b1;
				state_d     = ST_NEXT;
			end
			ST_NEXT: begin
				cmd.shift = 1'b1;
				if (status.u_last) begin
					cmd.take_acc = 1'b1;
					state_d      = ST_FIN;
				end else begin
					state_d = ST_MS1;
				end
			end
			ST_MS1: begin
				cmd.mul_start = 1'b1;
				cmd.sel_sq    = 1'b1;
				state_d       = ST_MS2;
			end
			ST_MS2: begin
				cmd.mul_end = 1'b1;
				cmd.sel_sq  = 1'b1;
				state_d     = ST_STEP;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The output item stays valid until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hdl/integer_power_unit.sv]
// Integer power unit: raises a signed base to a signed exponent, wrapping
// modulo 2^DATA_WIDTH, by square-and-multiply over the exponent's bits.
//
// The operands channel carries base and exponent; the results channel carries
// power and zero_to_negative. Both use a valid/ready handshake, and an item
// moves at a rising edge where both are high. Only the low DATA_WIDTH bits of
// each operand are used; power is sign-extended from DATA_WIDTH to 64 bits.
//
// One item is worked on at a time. Exponent zero, base one and any negative
// exponent need no multiplication. Otherwise the exponent's bits are worked
// through from the lowest: each multiplication uses the shared multiplier, first
// to register the partial products and then to sum them.
//
// A finished result sits in an output register, so the next item is accepted
// while the receiver stalls; a second result waits until the first is taken.
// Reset clears the sequencer and the output valid flag; no item is in flight.
`default_nettype none

module integer_power_unit #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ipu_in_if.sink     operands,
	ipu_out_if.source  results
);

	ipu_pkg::ipu_cmd_t    cmd;
	ipu_pkg::ipu_status_t status;
	logic                 in_ready;
	logic                 out_valid;
	logic signed [63:0]   power;
	logic                 zero_to_negative;

	ipu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operands.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ipu_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk              (clk),
		.cmd              (cmd),
		.status           (status),
		.base             (operands.base),
		.exponent         (operands.exponent),
		.power            (power),
		.zero_to_negative (zero_to_negative)
	);

	assign operands.ready           = in_ready;
	assign results.valid            = out_valid;
	assign results.power            = power;
	assign results.zero_to_negative = zero_to_negative;

endmodule

`default_nettype wire

[hdl/ipu_checker.sv]
`default_nettype none

// Port-level checks on the integer power unit.
module ipu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] power,
	input wire logic        zero_to_negative
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power) && $stable(zero_to_negative))
		else $error("result changed while stalled");

	// The error flag always comes with a zero power.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_to_negative |-> power == 64'd0)
		else $error("error flag with nonzero power");

	// One item at a time: the unit is busy right after it accepts an item.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// No result can appear in the cycle right after an item is accepted
	// unless one was already waiting.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind integer_power_unit ipu_checker u_ipu_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (operands.valid),
	.in_ready         (operands.ready),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.power            (results.power),
	.zero_to_negative (results.zero_to_negative)
);

`default_nettype wire
